@@ design/bcdcal_pkg.sv @@
// shared types, codes and the month length table for the bcd calendar clock
// no dependencies; used by the channel interfaces and all modules
package bcdcal_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [3:0] addr_type;
   typedef logic [3:0] digit_type;
   typedef logic [4:0] rdata_type;
   typedef logic [7:0] field_type;
   typedef logic [2:0] year_type;

   localparam mode_type MODE_TICK  = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;

   localparam addr_type ADDR_SEC_UNITS   = 4'd2;
   localparam addr_type ADDR_SEC_TENS    = 4'd3;
   localparam addr_type ADDR_MIN_UNITS   = 4'd4;
   localparam addr_type ADDR_MIN_TENS    = 4'd5;
   localparam addr_type ADDR_HOUR_UNITS  = 4'd6;
   localparam addr_type ADDR_HOUR_TENS   = 4'd7;
   localparam addr_type ADDR_DAY_UNITS   = 4'd8;
   localparam addr_type ADDR_DAY_TENS    = 4'd9;
   localparam addr_type ADDR_WEEKDAY     = 4'd10;
   localparam addr_type ADDR_MONTH_UNITS = 4'd11;
   localparam addr_type ADDR_MONTH_TENS  = 4'd12;
   localparam addr_type ADDR_LEAP        = 4'd13;
   localparam addr_type ADDR_YEAR        = 4'd15;

   localparam field_type SECONDS_LIMIT = 8'd60;
   localparam field_type MINUTES_LIMIT = 8'd60;
   localparam field_type HOURS_LIMIT   = 8'd24;
   localparam field_type MONTH_LIMIT   = 8'd13;

   // 1984 counts as year 84 in the weekday sum, plus the fixed 3 and 6
   localparam logic [9:0] WEEKDAY_BIAS = 10'd93;

   function automatic logic [4:0] days_in(input field_type month, input year_type year_off);
      logic [4:0] days;
      case (month)
         8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: days = 5'd31;
         8'd4, 8'd6, 8'd9, 8'd11:                   days = 5'd30;
         8'd2:    days = (year_off[1:0] == 2'd0) ? 5'd29 : 5'd28;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

@@ design/bcdcal_if.sv @@
// request and response channel interfaces for the bcd calendar clock
// depends on bcdcal_pkg
interface bcdcal_req_if;
   import bcdcal_pkg::*;
   logic      valid;
   logic      ready;
   mode_type  mode;
   addr_type  addr;
   digit_type wdata;
   modport source (output valid, mode, addr, wdata, input ready);
   modport sink   (input valid, mode, addr, wdata, output ready);
endinterface

interface bcdcal_rsp_if;
   import bcdcal_pkg::*;
   logic      valid;
   logic      ready;
   rdata_type rdata;
   modport source (output valid, rdata, input ready);
   modport sink   (input valid, rdata, output ready);
endinterface

@@ design/bcdcal_div10.sv @@
// splits an 8-bit field into tens and units digits
// reciprocal multiply by 205/2048, exact for all 8-bit values; uses bcdcal_pkg
module bcdcal_div10 (
   input  bcdcal_pkg::field_type value,
   output logic [4:0]            tens,
   output bcdcal_pkg::digit_type units
);
   import bcdcal_pkg::*;

   logic [15:0] prod;
   logic [7:0]  tens_x10;

   assign prod     = {8'd0, value} * 16'd205;
   assign tens     = prod[15:11];
   assign tens_x10 = {3'd0, tens} * 8'd10;
   assign units    = 4'(value - tens_x10);

endmodule

@@ design/bcd_calendar_clock_registers.sv @@
// bcd calendar clock: time and date counters behind decimal digit registers
// depends on bcdcal_pkg, bcdcal_if and bcdcal_div10
//
//   channel  dir  payload              handshake
//   req_ch   in   mode, addr, wdata    valid / ready
//   rsp_ch   out  rdata                valid / ready
//
// every request gives one response, once it has passed the input register and the response register
// one request per cycle if not stalled: an input register, the update and read logic,
// then a response register; counters change as the request leaves the input register
// reset is synchronous and sets 00:00:00, day 1, month 1, year offset 0
// a stalled response holds the input register, which then stops taking requests
module bcd_calendar_clock_registers (
   input  logic               clock,
   input  logic               reset,
   bcdcal_req_if.sink         req_ch,
   bcdcal_rsp_if.source       rsp_ch
);
   import bcdcal_pkg::*;

   // input register
   logic      s1_valid_ff;
   mode_type  s1_mode_ff;
   addr_type  s1_addr_ff;
   digit_type s1_wdata_ff;

   // response register
   logic      out_valid_ff;
   rdata_type rdata_ff, rdata_in;

   // clock state
   field_type seconds_ff, seconds_in;
   field_type minutes_ff, minutes_in;
   field_type hours_ff, hours_in;
   field_type day_ff, day_in;
   field_type month_ff, month_in;
   year_type  year_ff, year_in;

   logic      accept;
   logic      advance;

   field_type sel_field;
   logic      sel_hit;
   logic      sel_tens;
   logic [4:0] sel_tens_digit;
   digit_type sel_units_digit;
   field_type write_value;

   field_type tick_sec, tick_min, tick_hour, tick_day, tick_mon;
   year_type  tick_year;

   logic [9:0]  wd_sum;
   logic [22:0] wd_prod;
   logic [7:0]  wd_quot;
   logic [9:0]  wd_rem;

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.rdata = rdata_ff;

   // field addressed by the request
   always_comb begin
      sel_hit   = 1'b1;
      sel_field = '0;
      case (s1_addr_ff) inside
         ADDR_SEC_UNITS, ADDR_SEC_TENS:     sel_field = seconds_ff;
         ADDR_MIN_UNITS, ADDR_MIN_TENS:     sel_field = minutes_ff;
         ADDR_HOUR_UNITS, ADDR_HOUR_TENS:   sel_field = hours_ff;
         ADDR_DAY_UNITS, ADDR_DAY_TENS:     sel_field = day_ff;
         ADDR_MONTH_UNITS, ADDR_MONTH_TENS: sel_field = month_ff;
         default:                           sel_hit   = 1'b0;
      endcase
      sel_tens = (s1_addr_ff inside {ADDR_SEC_TENS, ADDR_MIN_TENS, ADDR_HOUR_TENS,
                                     ADDR_DAY_TENS, ADDR_MONTH_TENS});
   end

   bcdcal_div10 u_div10 (
      .value (sel_field),
      .tens  (sel_tens_digit),
      .units (sel_units_digit)
   );

   // digit write keeps the other digit, wraps at 8 bits
   always_comb begin
      if (sel_tens) begin
         write_value = 8'({4'd0, s1_wdata_ff} * 8'd10) + {4'd0, sel_units_digit};
      end else begin
         write_value = 8'({3'd0, sel_tens_digit} * 8'd10) + {4'd0, s1_wdata_ff};
      end
   end

   // one-second tick, carries only on exact limit match
   always_comb begin
      tick_sec  = seconds_ff + 8'd1;
      tick_min  = minutes_ff;
      tick_hour = hours_ff;
      tick_day  = day_ff;
      tick_mon  = month_ff;
      tick_year = year_ff;
      if (tick_sec == SECONDS_LIMIT) begin
         tick_sec = '0;
         tick_min = minutes_ff + 8'd1;
      end
      if (tick_min == MINUTES_LIMIT) begin
         tick_min  = '0;
         tick_hour = hours_ff + 8'd1;
      end
      if (tick_hour == HOURS_LIMIT) begin
         tick_hour = '0;
         tick_day  = day_ff + 8'd1;
      end
      if (tick_day == {3'd0, days_in(month_ff, year_ff)} + 8'd1) begin
         tick_day = 8'd1;
         tick_mon = month_ff + 8'd1;
      end
      if (tick_mon == MONTH_LIMIT) begin
         tick_mon  = 8'd1;
         tick_year = year_ff + 3'd1;
      end
   end

   // weekday: sum mod 7 through multiply by 4682/32768
   assign wd_sum  = {2'd0, day_ff} + {2'd0, month_ff} + {7'd0, year_ff} + WEEKDAY_BIAS;
   assign wd_prod = {13'd0, wd_sum} * 23'd4682;
   assign wd_quot = wd_prod[22:15];
   assign wd_rem  = wd_sum - 10'({2'd0, wd_quot} * 10'd7);

   always_comb begin
      seconds_in = seconds_ff;
      minutes_in = minutes_ff;
      hours_in   = hours_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      rdata_in   = '0;
      case (s1_mode_ff)
         MODE_TICK: begin
            seconds_in = tick_sec;
            minutes_in = tick_min;
            hours_in   = tick_hour;
            day_in     = tick_day;
            month_in   = tick_mon;
            year_in    = tick_year;
         end
         MODE_WRITE: begin
            case (s1_addr_ff) inside
               ADDR_SEC_UNITS, ADDR_SEC_TENS:     seconds_in = write_value;
               ADDR_MIN_UNITS, ADDR_MIN_TENS:     minutes_in = write_value;
               ADDR_HOUR_UNITS, ADDR_HOUR_TENS:   hours_in   = write_value;
               ADDR_DAY_UNITS, ADDR_DAY_TENS:     day_in     = write_value;
               ADDR_MONTH_UNITS, ADDR_MONTH_TENS: month_in   = write_value;
               ADDR_YEAR:                         year_in    = s1_wdata_ff[2:0];
               default:                           ;
            endcase
         end
         MODE_READ: begin
            case (s1_addr_ff)
               ADDR_YEAR:    rdata_in = {2'd0, year_ff};
               ADDR_LEAP:    rdata_in = 5'(5'd8 >> year_ff[1:0]);
               ADDR_WEEKDAY: rdata_in = {2'd0, wd_rem[2:0]} + 5'd1;
               default: begin
                  if (sel_hit) begin
                     rdata_in = sel_tens ? sel_tens_digit : {1'b0, sel_units_digit};
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seconds_ff   <= '0;
         minutes_ff   <= '0;
         hours_ff     <= '0;
         day_ff       <= 8'd1;
         month_ff     <= 8'd1;
         year_ff      <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            seconds_ff   <= seconds_in;
            minutes_ff   <= minutes_in;
            hours_ff     <= hours_in;
            day_ff       <= day_in;
            month_ff     <= month_in;
            year_ff      <= year_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_ch.mode;
         s1_addr_ff  <= req_ch.addr;
         s1_wdata_ff <= req_ch.wdata;
      end
      if (advance) begin
         rdata_ff <= rdata_in;
      end
   end

endmodule
